FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the game pad shifter.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: property failed");

// Check that a condition implies a consequence in the same cycle.
`define CHK_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication failed");

`endif

FILE: rtl/core/gdcs_pkg.sv
// Shared types and constants for the game pad direction counter shifter.
// Used by the interfaces, the axis unit and the top level.
package gdcs_pkg;

	localparam int CNT_W_DEF  = 16;
	localparam int FRAME_BITS = 8;
	localparam int STEP_W     = 12;
	localparam int ACTION_W   = 2;
	localparam int CODE_W     = 3;
	localparam int WORD_W     = FRAME_BITS;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);

	// Bit places in the button word
	localparam int BIT_START = 3;
	localparam int BIT_UP    = 4;
	localparam int BIT_DOWN  = 5;
	localparam int BIT_LEFT  = 6;
	localparam int BIT_RIGHT = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_BUTTON = 2'd0,
		ACT_FRAME  = 2'd1,
		ACT_LATCH  = 2'd2,
		ACT_CLOCK  = 2'd3
	} action_t;

	typedef enum logic [CODE_W-1:0] {
		BTN_A      = 3'd0,
		BTN_B      = 3'd1,
		BTN_SELECT = 3'd2,
		BTN_START  = 3'd3,
		BTN_UP     = 3'd4,
		BTN_DOWN   = 3'd5,
		BTN_LEFT   = 3'd6,
		BTN_RIGHT  = 3'd7
	} btn_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_SHIFT = 2'd2
	} phase_t;

	// Requests from the decoder to one axis counter
	typedef struct packed {
		logic press_pos;
		logic press_neg;
		logic frame;
	} axis_cmd_t;

	// Button word updates reported by one axis counter
	typedef struct packed {
		logic set_pos;
		logic set_neg;
		logic clear;
	} axis_flags_t;

endpackage

FILE: rtl/core/gdcs_ifs.sv
// Valid/ready channel interfaces for the game pad direction counter shifter.
// Depends on gdcs_pkg for field widths.

interface gdcs_cmd_if;
	import gdcs_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CODE_W-1:0]   button_code;
	logic                pressed;
	modport source (output valid, action, button_code, pressed, input ready);
	modport sink   (input valid, action, button_code, pressed, output ready);
endinterface

interface gdcs_rsp_if;
	import gdcs_pkg::*;
	logic              valid;
	logic              ready;
	logic              data_line;
	logic [WORD_W-1:0] pad_word;
	logic              sending;
	modport source (output valid, data_line, pad_word, sending, input ready);
	modport sink   (input valid, data_line, pad_word, sending, output ready);
endinterface

interface gdcs_cfg_if;
	import gdcs_pkg::*;
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/gdcs_axis.sv
// One signed axis counter: saturating press update and frame-time decay.
// Depends on gdcs_pkg for the step width and the axis structs.
module gdcs_axis #(
	parameter int CNT_W = gdcs_pkg::CNT_W_DEF
) (
	input  logic [gdcs_pkg::STEP_W-1:0] step,
	input  gdcs_pkg::axis_cmd_t         cmd,
	input  logic signed [CNT_W-1:0]     count,
	output logic signed [CNT_W-1:0]     count_next,
	output gdcs_pkg::axis_flags_t       flags
);
	import gdcs_pkg::*;

	// Room for the counter, a 4x step and the carry of one add
	localparam int EW = ((CNT_W > STEP_W + 2) ? CNT_W : STEP_W + 2) + 2;

	logic signed [EW-1:0] cnt_e, step_e, zone_e, base_e, sum_e, max_e, min_e;

	assign cnt_e  = {{(EW-CNT_W){count[CNT_W-1]}}, count};
	assign step_e = {{(EW-STEP_W){1'b0}}, step};
	assign zone_e = {{(EW-STEP_W-2){1'b0}}, step, 2'b00};
	assign max_e  = {{(EW-CNT_W+1){1'b0}}, {(CNT_W-1){1'b1}}};
	assign min_e  = {{(EW-CNT_W+1){1'b1}}, {(CNT_W-1){1'b0}}};

	// Press: drop an opposite-signed count, then add or subtract the step; frame: decay
	always_comb begin
		count_next = count;
		flags      = '0;
		base_e     = cnt_e;
		sum_e      = cnt_e;
		priority if (cmd.press_pos) begin
			base_e = (cnt_e < 0) ? '0 : cnt_e;
			sum_e  = base_e + step_e;
			count_next = (sum_e > max_e) ? max_e[CNT_W-1:0] : sum_e[CNT_W-1:0];
		end else if (cmd.press_neg) begin
			base_e = (cnt_e > 0) ? '0 : cnt_e;
			sum_e  = base_e - step_e;
			count_next = (sum_e < min_e) ? min_e[CNT_W-1:0] : sum_e[CNT_W-1:0];
		end else if (cmd.frame) begin
			// Inside the dead zone clear both bits, else set one and decay
			if ((count == '0) || ((cnt_e > -zone_e) && (cnt_e < zone_e))) begin
				flags.clear = 1'b1;
			end else if (cnt_e > 0) begin
				flags.set_pos = 1'b1;
				count_next = count - CNT_W'(1);
			end else begin
				flags.set_neg = 1'b1;
				count_next = count + CNT_W'(1);
			end
		end else begin
			// Hold the count for every other word
			count_next = count;
		end
	end

endmodule

FILE: rtl/core/gamepad_direction_counter_shifter_unit.sv
// Top level of the game pad direction counter shifter: input stage, button
// word, axis counters, serial frame sequencer and result register.
// Depends on gdcs_pkg, gdcs_ifs and gdcs_axis.
//
//   channel | role  | moves
//   --------+-------+--------------------------------------------
//   cmd     | sink  | word of action, button_code, pressed
//   rsp     | src   | word of data_line, pad_word, sending
//   cfg     | sink  | word of dir_step, always ready
//
// Each accepted word passes through the input register, then through the
// state update into the result register.
// One word is accepted every cycle while the result register drains.
// A stalled result holds the input stage; cmd.ready is high while the input stage is empty or advances.
// Reset clears the counters and the word, loads dir_step with 8 and
// drives the line high.
module gamepad_direction_counter_shifter_unit #(
	parameter int COUNTER_WIDTH = gdcs_pkg::CNT_W_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gdcs_cmd_if.sink   cmd,
	gdcs_rsp_if.source rsp,
	gdcs_cfg_if.sink   cfg
);
	import gdcs_pkg::*;

	localparam int IDX_W = $clog2(FRAME_BITS);
	localparam int POS_W = IDX_W + 1;

	// Input stage
	logic              valid_s1;
	action_t           action_s1;
	btn_t              code_s1;
	logic              pressed_s1;
	logic              advance;

	// Block state
	logic [STEP_W-1:0]               step_q;
	logic signed [COUNTER_WIDTH-1:0] horiz_q, vert_q, horiz_d, vert_d;
	logic [WORD_W-1:0]               word_q, word_d, snap_q, snap_d;
	logic [POS_W-1:0]                pos_q, pos_d, pos_inc;
	phase_t                          phase_q, phase_d;
	logic                            line_q, line_d;

	// Result register
	logic              rsp_valid_q;
	logic              data_line_q;
	logic [WORD_W-1:0] pad_word_q;
	logic              sending_q;

	axis_cmd_t   h_cmd, v_cmd;
	axis_flags_t h_flags, v_flags;
	logic        is_button, is_frame, is_latch, is_clock;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Hold the accepted word until the result register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1  <= action_t'(cmd.action);
			code_s1    <= btn_t'(cmd.button_code);
			pressed_s1 <= cmd.pressed;
		end
	end

	// Decode the action
	assign is_button = (action_s1 == ACT_BUTTON);
	assign is_frame  = (action_s1 == ACT_FRAME);
	assign is_latch  = (action_s1 == ACT_LATCH);
	assign is_clock  = (action_s1 == ACT_CLOCK);

	assign h_cmd.press_pos = is_button && pressed_s1 && (code_s1 == BTN_RIGHT);
	assign h_cmd.press_neg = is_button && pressed_s1 && (code_s1 == BTN_LEFT);
	assign h_cmd.frame     = is_frame;
	assign v_cmd.press_pos = is_button && pressed_s1 && (code_s1 == BTN_UP);
	assign v_cmd.press_neg = is_button && pressed_s1 && (code_s1 == BTN_DOWN);
	assign v_cmd.frame     = is_frame;

	gdcs_axis #(.CNT_W(COUNTER_WIDTH)) u_horiz (
		.step       (step_q),
		.cmd        (h_cmd),
		.count      (horiz_q),
		.count_next (horiz_d),
		.flags      (h_flags)
	);

	gdcs_axis #(.CNT_W(COUNTER_WIDTH)) u_vert (
		.step       (step_q),
		.cmd        (v_cmd),
		.count      (vert_q),
		.count_next (vert_d),
		.flags      (v_flags)
	);

	// Update the button word from events and axis flags
	always_comb begin
		word_d = word_q;
		if (is_button && (code_s1 <= BTN_START)) begin
			word_d[code_s1[1:0]] = pressed_s1;
		end
		if (is_frame) begin
			if (v_flags.clear) begin
				word_d[BIT_UP]   = 1'b0;
				word_d[BIT_DOWN] = 1'b0;
			end
			if (v_flags.set_pos) word_d[BIT_UP] = 1'b1;
			if (v_flags.set_neg) word_d[BIT_DOWN] = 1'b1;
			if (h_flags.clear) begin
				word_d[BIT_RIGHT] = 1'b0;
				word_d[BIT_LEFT]  = 1'b0;
			end
			if (h_flags.set_pos) word_d[BIT_RIGHT] = 1'b1;
			if (h_flags.set_neg) word_d[BIT_LEFT] = 1'b1;
		end
	end

	assign pos_inc = pos_q + POS_W'(1);

	// Sequencer next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_frame && (word_d != '0)) phase_d = PH_ARMED;
			end
			PH_ARMED: begin
				if (is_latch) phase_d = PH_SHIFT;
			end
			PH_SHIFT: begin
				if (is_clock && (pos_inc >= POS_W'(FRAME_BITS))) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Sequencer outputs: snapshot capture, bit position, line level
	always_comb begin
		snap_d = snap_q;
		pos_d  = pos_q;
		line_d = line_q;
		if (is_frame && (word_d != '0) && (phase_q != PH_SHIFT)) begin
			snap_d = word_d;
		end
		if (is_latch && (phase_q == PH_ARMED)) begin
			pos_d  = '0;
			line_d = !snap_q[0];
		end
		if (is_clock && (phase_q == PH_SHIFT)) begin
			if (pos_inc < POS_W'(FRAME_BITS)) begin
				pos_d  = pos_inc;
				line_d = !snap_q[pos_inc[IDX_W-1:0]];
			end else begin
				pos_d  = '0;
				line_d = 1'b1;
			end
		end
	end

	// Commit state when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q <= '0;
			vert_q  <= '0;
			word_q  <= '0;
			snap_q  <= '0;
			pos_q   <= '0;
			phase_q <= PH_IDLE;
			line_q  <= 1'b1;
		end else if (advance) begin
			horiz_q <= horiz_d;
			vert_q  <= vert_d;
			word_q  <= word_d;
			snap_q  <= snap_d;
			pos_q   <= pos_d;
			phase_q <= phase_d;
			line_q  <= line_d;
		end
	end

	// Load the step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			step_q <= cfg.data;
		end
	end

	// Result register: fill on advance, drain on rsp handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_line_q <= line_d;
			pad_word_q  <= word_d;
			sending_q   <= (phase_d != PH_IDLE);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data_line = data_line_q;
	assign rsp.pad_word  = pad_word_q;
	assign rsp.sending   = sending_q;

endmodule

FILE: rtl/core/gdcs_chk.sv
// Port-level checker for the game pad direction counter shifter, with bind.
// Depends on gdcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gdcs_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        data_line,
	input logic [gdcs_pkg::WORD_W-1:0] pad_word,
	input logic                        sending
);
	import gdcs_pkg::*;

	// A stalled result keeps its word
	`CHK_PROP(a_rsp_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pad_word) && $stable(data_line) && $stable(sending)))

	// The line idles high whenever no frame is armed or shifting
	`CHK_IMPL(a_idle_high, clk, arst_n, rsp_valid && !sending, data_line)

	// With the sink ready, an accepted word passes the input register, then shows up in the result register
	`CHK_PROP(a_latency, clk, arst_n, (cmd_valid && cmd_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid)

	// Input stage frees whenever the result register drains
	`CHK_IMPL(a_ready_flow, clk, arst_n, rsp_ready, cmd_ready)

endmodule

bind gamepad_direction_counter_shifter_unit gdcs_chk u_gdcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.data_line (rsp.data_line),
	.pad_word  (rsp.pad_word),
	.sending   (rsp.sending)
);
